>>> rtl/core/tscc_pkg.sv
// Shared types and constants for the calibrated temperature and supply converter.
package tscc_pkg;

   localparam int unsigned SPAN_MDEG    = 80000;
   localparam int unsigned BASE_MDEG    = 30000;
   localparam int unsigned SUPPLY_SCALE = 52800;

   localparam int unsigned CAL_W   = 12;
   localparam int unsigned RDG_W   = 16;
   localparam int unsigned TEMP_W  = 32;
   localparam int unsigned SUP_W   = 28;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_REF_ZERO  = 2'd1,
      ERR_CAL_EQUAL = 2'd2
   } err_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VREFINT_FACTORY = 2'd0,
      CSR_TEMP_POINT_LOW  = 2'd1,
      CSR_TEMP_POINT_HIGH = 2'd2
   } csr_index_type;

endpackage

>>> rtl/core/tscc_if.sv
// Request and response channel interfaces of the converter.
interface tscc_req_if import tscc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [RDG_W-1:0] sensor_reading;
   logic [RDG_W-1:0] reference_reading;

   modport source (output valid, sensor_reading, reference_reading, input ready);
   modport sink (input valid, sensor_reading, reference_reading, output ready);
endinterface

interface tscc_rsp_if import tscc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_mdeg;
   logic [SUP_W-1:0]         supply_mv;
   logic [1:0]               error_code;

   modport source (output valid, temperature_mdeg, supply_mv, error_code, input ready);
   modport sink (input valid, temperature_mdeg, supply_mv, error_code, output ready);
endinterface

>>> rtl/core/tscc_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module tscc_div_pipe #(
   parameter int unsigned NW = 45,
   parameter int unsigned DW = 16,
   parameter int unsigned SW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [SW-1:0] side_in,
   output logic          out_valid,
   output logic [NW-1:0] quo,
   output logic [SW-1:0] side_out
);

   // stages 1 to NW are registers, stage NW is the output
   logic          vld_ff  [1:NW];
   logic [DW-1:0] rem_ff  [1:NW];
   logic [NW-1:0] nq_ff   [1:NW];
   logic [DW-1:0] den_ff  [1:NW];
   logic [SW-1:0] side_ff [1:NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic          cur_vld;
      logic [DW-1:0] cur_rem;
      logic [NW-1:0] cur_nq;
      logic [DW-1:0] cur_den;
      logic [SW-1:0] cur_side;
      logic [DW:0]   shift_rem;
      logic [DW:0]   diff;
      logic          ge;
      logic [DW-1:0] rem_in;
      logic [NW-1:0] nq_in;

      // stage input: the ports for the first stage, else the previous registers
      if (k == 0) begin : g_first
         assign cur_vld  = in_valid;
         assign cur_rem  = '0;
         assign cur_nq   = num;
         assign cur_den  = den;
         assign cur_side = side_in;
      end else begin : g_next
         assign cur_vld  = vld_ff[k];
         assign cur_rem  = rem_ff[k];
         assign cur_nq   = nq_ff[k];
         assign cur_den  = den_ff[k];
         assign cur_side = side_ff[k];
      end

      // shift in next numerator bit, subtract when it fits
      always_comb begin
         shift_rem = {cur_rem, cur_nq[NW-1]};
         diff      = shift_rem - {1'b0, cur_den};
         ge        = shift_rem >= {1'b0, cur_den};
         rem_in    = ge ? diff[DW-1:0] : shift_rem[DW-1:0];
         nq_in     = {cur_nq[NW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= cur_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            nq_ff[k+1]   <= nq_in;
            den_ff[k+1]  <= cur_den;
            side_ff[k+1] <= cur_side;
         end
      end
   end

   assign out_valid = vld_ff[NW];
   assign quo       = nq_ff[NW];
   assign side_out  = side_ff[NW];

endmodule

>>> rtl/core/temp_sensor_calibrated_convert_unit.sv
// Top level of the two-point calibrated temperature and supply converter.
//
// Usage:
//   req_chan carries one pair of left-aligned 16-bit readings (temperature
//   sensor and internal reference); rsp_chan returns temperature in
//   millidegrees C, supply in millivolts and an error code per transaction.
//   csr_we/csr_index/csr_wdata write the three 12-bit factory calibration
//   words; write them only while no transaction is in flight.
//   A request passes two multiply stages, a 45-stage divider for the
//   ratiometric and supply quotients, one subtract stage, a 32-stage
//   divider for the slope and a final offset and saturate stage. One
//   transaction is accepted per cycle unless the pipeline is stalled.
//   The whole pipeline advances together; when the response is held and
//   not taken, every stage holds and req_chan.ready drops.
//   Reset empties the pipeline and loads the calibration words with their
//   factory defaults (1520, 1750, 1310).
module temp_sensor_calibrated_convert_unit import tscc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tscc_req_if.sink             req_chan,
   tscc_rsp_if.source           rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_wdata
);

   localparam int unsigned P1_W  = RDG_W + CAL_W;   // sensor * vcal
   localparam int unsigned P2_W  = P1_W + 17;       // * 80000
   localparam int unsigned LOS_W = CAL_W + 17;      // lo * 80000
   localparam int unsigned MAG_W = 32;
   localparam int unsigned S1_W  = LOS_W + CAL_W + 1;
   localparam int unsigned S2_W  = 1 + SUP_W + 2;

   // calibration registers
   logic [CAL_W-1:0] vcal_ff, lo_ff, hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcal_ff <= CAL_W'(1520);
         lo_ff   <= CAL_W'(1750);
         hi_ff   <= CAL_W'(1310);
      end else if (csr_we) begin
         case (csr_index)
            CSR_VREFINT_FACTORY: vcal_ff <= csr_wdata;
            CSR_TEMP_POINT_LOW:  lo_ff   <= csr_wdata;
            CSR_TEMP_POINT_HIGH: hi_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // whole pipeline advances when the output register is free or taken
   logic adv;
   logic out_valid_ff;
   assign adv = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // stage 1: products, calibration slope, error detect
   logic             s1_valid_ff;
   logic [P1_W-1:0]  s1_prod_ff;
   logic [SUP_W-1:0] s1_sup_ff;
   logic [LOS_W-1:0] s1_los_ff;
   logic [CAL_W-1:0] s1_dmag_ff;
   logic             s1_dneg_ff;
   logic [RDG_W-1:0] s1_ref_ff;
   err_code_type     s1_err_ff;

   logic [CAL_W:0]   dsub;
   logic             dneg_in;
   logic [CAL_W-1:0] dmag_in;
   err_code_type     err_in;

   always_comb begin
      dsub    = {1'b0, hi_ff} - {1'b0, lo_ff};
      dneg_in = dsub[CAL_W];
      dmag_in = dneg_in ? CAL_W'(-dsub) : dsub[CAL_W-1:0];
      if (req_chan.reference_reading == '0) begin
         err_in = ERR_REF_ZERO;
      end else if (hi_ff == lo_ff) begin
         err_in = ERR_CAL_EQUAL;
      end else begin
         err_in = ERR_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= P1_W'(req_chan.sensor_reading) * P1_W'(vcal_ff);
         s1_sup_ff  <= SUP_W'(vcal_ff) * SUP_W'(SUPPLY_SCALE);
         s1_los_ff  <= LOS_W'(lo_ff) * LOS_W'(SPAN_MDEG);
         s1_dmag_ff <= dmag_in;
         s1_dneg_ff <= dneg_in;
         s1_ref_ff  <= req_chan.reference_reading;
         s1_err_ff  <= err_in;
      end
   end

   // stage 2: scale by the span
   logic             s2_valid_ff;
   logic [P2_W-1:0]  s2_prod_ff;
   logic [SUP_W-1:0] s2_sup_ff;
   logic [LOS_W-1:0] s2_los_ff;
   logic [CAL_W-1:0] s2_dmag_ff;
   logic             s2_dneg_ff;
   logic [RDG_W-1:0] s2_ref_ff;
   err_code_type     s2_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_prod_ff <= P2_W'(s1_prod_ff) * P2_W'(SPAN_MDEG);
         s2_sup_ff  <= s1_sup_ff;
         s2_los_ff  <= s1_los_ff;
         s2_dmag_ff <= s1_dmag_ff;
         s2_dneg_ff <= s1_dneg_ff;
         s2_ref_ff  <= s1_ref_ff;
         s2_err_ff  <= s1_err_ff;
      end
   end

   // ratiometric and supply quotients, same divisor, aligned stages
   logic             d1_valid, d1s_valid;
   logic [P2_W-1:0]  d1_quo, d1s_quo;
   logic [S1_W-1:0]  d1_side;
   logic [1:0]       d1s_side;

   tscc_div_pipe #(.NW(P2_W), .DW(RDG_W), .SW(S1_W)) u_div_ratio (
      .clock, .reset, .en(adv),
      .in_valid(s2_valid_ff), .num(s2_prod_ff), .den(s2_ref_ff),
      .side_in({s2_los_ff, s2_dmag_ff, s2_dneg_ff}),
      .out_valid(d1_valid), .quo(d1_quo), .side_out(d1_side)
   );

   tscc_div_pipe #(.NW(P2_W), .DW(RDG_W), .SW(2)) u_div_supply (
      .clock, .reset, .en(adv),
      .in_valid(s2_valid_ff), .num(P2_W'(s2_sup_ff)), .den(s2_ref_ff),
      .side_in(s2_err_ff),
      .out_valid(d1s_valid), .quo(d1s_quo), .side_out(d1s_side)
   );

   // stage 3: saturate, subtract low point, split sign and magnitude
   logic [LOS_W-1:0] d1_los;
   logic [CAL_W-1:0] d1_dmag;
   logic             d1_dneg;
   logic [30:0]      a_sat;
   logic [32:0]      diff;
   logic             diff_neg;
   logic [MAG_W-1:0] diff_mag;

   assign {d1_los, d1_dmag, d1_dneg} = d1_side;

   always_comb begin
      a_sat    = (|d1_quo[P2_W-1:31]) ? 31'h7FFF_FFFF : d1_quo[30:0];
      diff     = {2'b00, a_sat} - 33'(d1_los);
      diff_neg = diff[32];
      diff_mag = diff_neg ? MAG_W'(-diff) : diff[MAG_W-1:0];
   end

   logic             s3_valid_ff;
   logic [MAG_W-1:0] s3_mag_ff;
   logic [CAL_W-1:0] s3_dmag_ff;
   logic             s3_qneg_ff;
   logic [SUP_W-1:0] s3_sup_ff;
   logic [1:0]       s3_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= d1_valid && d1s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_mag_ff  <= diff_mag;
         s3_dmag_ff <= d1_dmag;
         s3_qneg_ff <= diff_neg ^ d1_dneg;
         s3_sup_ff  <= d1s_quo[SUP_W-1:0];
         s3_err_ff  <= d1s_side;
      end
   end

   // slope division on magnitudes
   logic             d2_valid;
   logic [MAG_W-1:0] d2_quo;
   logic [S2_W-1:0]  d2_side;

   tscc_div_pipe #(.NW(MAG_W), .DW(CAL_W), .SW(S2_W)) u_div_slope (
      .clock, .reset, .en(adv),
      .in_valid(s3_valid_ff), .num(s3_mag_ff), .den(s3_dmag_ff),
      .side_in({s3_qneg_ff, s3_sup_ff, s3_err_ff}),
      .out_valid(d2_valid), .quo(d2_quo), .side_out(d2_side)
   );

   // stage 4: apply sign, add base, saturate, mask errors
   logic               d2_qneg;
   logic [SUP_W-1:0]   d2_sup;
   err_code_type       d2_err;
   logic signed [33:0] b_sgn, t_sum;
   logic [TEMP_W-1:0]  t_sat;

   assign d2_qneg = d2_side[S2_W-1];
   assign d2_sup  = d2_side[S2_W-2:2];
   assign d2_err  = err_code_type'(d2_side[1:0]);

   always_comb begin
      b_sgn = d2_qneg ? -$signed({2'b00, d2_quo}) : $signed({2'b00, d2_quo});
      t_sum = b_sgn + 34'sd30000;
      if (t_sum > 34'sh0_7FFF_FFFF) begin
         t_sat = 32'h7FFF_FFFF;
      end else if (t_sum < -34'sh0_8000_0000) begin
         t_sat = 32'h8000_0000;
      end else begin
         t_sat = t_sum[TEMP_W-1:0];
      end
   end

   logic [TEMP_W-1:0] temp_ff;
   logic [SUP_W-1:0]  sup_ff;
   err_code_type      err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         temp_ff <= (d2_err == ERR_OK) ? t_sat : '0;
         sup_ff  <= (d2_err == ERR_OK) ? d2_sup : '0;
         err_ff  <= d2_err;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.temperature_mdeg = temp_ff;
   assign rsp_chan.supply_mv        = sup_ff;
   assign rsp_chan.error_code       = err_ff;

`ifndef SYNTHESIS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.error_code != ERR_OK) |->
      (rsp_chan.temperature_mdeg == '0 && rsp_chan.supply_mv == '0))
      else $error("error response carries nonzero data");

   a_err_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.error_code == ERR_OK ||
      rsp_chan.error_code == ERR_REF_ZERO || rsp_chan.error_code == ERR_CAL_EQUAL))
      else $error("illegal error code");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while pipeline stalled");
`endif

endmodule

>>> dv/tscc_checker.sv
// Checker for the converter: watches the channels, predicts each result and compares.
module tscc_checker import tscc_pkg::*; (
   input  logic clock,
   input  logic reset,
   tscc_req_if  req_chan,
   tscc_rsp_if  rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_wdata,
   output int unsigned          fail_count,
   output int unsigned          pending_count
);

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_mdeg;
      logic [SUP_W-1:0]         supply_mv;
      err_code_type             error_code;
   } reading_result_type;

   // Calibration words as the block should hold them
   logic [CAL_W-1:0] cal_vrefint;
   logic [CAL_W-1:0] cal_low;
   logic [CAL_W-1:0] cal_high;

   reading_result_type expected_readings[$];

   assign pending_count = expected_readings.size();

   function automatic longint clamp_int32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Ratiometric temperature and supply from one reading pair
   function automatic reading_result_type convert_reading(logic [RDG_W-1:0] sensor,
                                                          logic [RDG_W-1:0] refr);
      reading_result_type res;
      longint span;
      longint base;
      longint scale;
      longint s;
      longint r;
      longint vcal;
      longint lo;
      longint hi;
      longint a;
      longint b;
      span  = SPAN_MDEG;
      base  = BASE_MDEG;
      scale = SUPPLY_SCALE;
      s     = longint'(sensor);
      r     = longint'(refr);
      vcal  = longint'(cal_vrefint);
      lo    = longint'(cal_low);
      hi    = longint'(cal_high);
      res.temperature_mdeg = '0;
      res.supply_mv        = '0;
      res.error_code       = ERR_OK;
      if (r == 0) begin
         res.error_code = ERR_REF_ZERO;
      end else if (hi == lo) begin
         res.error_code = ERR_CAL_EQUAL;
      end else begin
         a = clamp_int32(s * vcal * span / r);
         b = (a - lo * span) / (hi - lo);
         res.temperature_mdeg = TEMP_W'(clamp_int32(b + base));
         res.supply_mv        = SUP_W'(scale * vcal / r);
      end
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("ERROR %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial fail_count = 0;

   // Track calibration writes; index 3 is ignored
   always @(posedge clock) begin
      if (reset) begin
         cal_vrefint <= 12'd1520;
         cal_low     <= 12'd1750;
         cal_high    <= 12'd1310;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VREFINT_FACTORY: cal_vrefint <= csr_wdata;
            CSR_TEMP_POINT_LOW:  cal_low     <= csr_wdata;
            CSR_TEMP_POINT_HIGH: cal_high    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Predict on request transaction, compare on response transaction
   always @(posedge clock) begin
      reading_result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            expected_readings.push_back(convert_reading(req_chan.sensor_reading,
                                                        req_chan.reference_reading));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = expected_readings.pop_front();
               if (rsp_chan.temperature_mdeg !== want.temperature_mdeg)
                  report_mismatch($sformatf("temperature_mdeg got %0d want %0d",
                                  rsp_chan.temperature_mdeg, want.temperature_mdeg));
               if (rsp_chan.supply_mv !== want.supply_mv)
                  report_mismatch($sformatf("supply_mv got %0d want %0d",
                                  rsp_chan.supply_mv, want.supply_mv));
               if (rsp_chan.error_code !== want.error_code)
                  report_mismatch($sformatf("error_code got %0d want %0d",
                                  rsp_chan.error_code, want.error_code));
            end
         end
      end
   end

endmodule

>>> dv/testbench.sv
// Testbench top: clock, reset, stimulus, idling and final verdict for the converter.
module testbench import tscc_pkg::*; ();

   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT  = 20000;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAL_W-1:0]     csr_wdata;
   int unsigned fail_count;
   int unsigned pending_count;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int quiet_cycles;

   tscc_req_if req_chan ();
   tscc_rsp_if rsp_chan ();

   temp_sensor_calibrated_convert_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan.sink),
      .rsp_chan  (rsp_chan.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tscc_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      reset                      = 1'b1;
      csr_we                     = 1'b0;
      csr_index                  = '0;
      csr_wdata                  = '0;
      req_chan.valid             = 1'b0;
      req_chan.sensor_reading    = '0;
      req_chan.reference_reading = '0;
      rsp_chan.ready             = 1'b0;
      send_idle_pct              = 0;
      recv_stall_pct             = 0;
      hold_cycles                = 0;
   end

   // Receiver: long hold-off when asked, else random stalls
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles    <= hold_cycles - 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_reading(logic [RDG_W-1:0] sensor, logic [RDG_W-1:0] refr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.sensor_reading    <= sensor;
      req_chan.reference_reading <= refr;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_cal(csr_index_type idx, logic [CAL_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly realistic readings, with extremes and zero reference mixed in
   task automatic send_random_reading();
      logic [RDG_W-1:0] sensor;
      logic [RDG_W-1:0] refr;
      case ($urandom_range(9))
         0:       sensor = $urandom_range(3) == 0 ? 16'hFFFF : 16'h0000;
         1, 2, 3: sensor = $urandom_range(65535);
         default: sensor = $urandom_range(32000, 20000);
      endcase
      case ($urandom_range(19))
         0:       refr = '0;
         1:       refr = $urandom_range(15, 1);
         2, 3, 4: refr = $urandom_range(65535);
         5:       refr = 16'hFFFF;
         default: refr = $urandom_range(26000, 22000);
      endcase
      send_reading(sensor, refr);
   endtask

   initial begin
      logic [3*CAL_W-1:0] cal_sets[7];
      cal_sets[0] = {12'd1520, 12'd1750, 12'd1310};
      cal_sets[1] = {12'd4095, 12'd0,    12'd4095};
      cal_sets[2] = {12'd0,    12'd4095, 12'd0};
      cal_sets[3] = {12'd1650, 12'd1000, 12'd1000};
      cal_sets[4] = {12'd4095, 12'd4095, 12'd0};
      cal_sets[5] = {12'($urandom), 12'($urandom), 12'($urandom)};
      cal_sets[6] = {12'd1, 12'd2000, 12'd1999};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and the special cases under reset calibration
      send_reading(16'h0000, 16'h0000);
      send_reading(16'hFFFF, 16'h0000);
      send_reading(16'hFFFF, 16'h0001);
      send_reading(16'h0000, 16'h0001);
      send_reading(16'h0000, 16'hFFFF);
      send_reading(16'hFFFF, 16'hFFFF);
      send_reading(16'h0001, 16'hFFFF);
      send_reading(16'h5555, 16'hAAAA);
      send_reading(16'hAAAA, 16'h5555);
      send_reading(16'd28000, 16'd24320);
      send_reading(16'd20960, 16'd24320);
      send_reading(16'd32768, 16'd2);
      send_reading(16'hFFFF, 16'd3);
      wait_idle();
      // Unused register index must be ignored
      write_cal(csr_index_type'(2'd3), 12'hFFF);
      wait_idle();
      send_reading(16'd28000, 16'd24320);
      send_reading(16'hFFFF, 16'd1);
      wait_idle();

      for (int p = 0; p < 7; p++) begin
         write_cal(CSR_VREFINT_FACTORY, cal_sets[p][3*CAL_W-1:2*CAL_W]);
         write_cal(CSR_TEMP_POINT_LOW,  cal_sets[p][2*CAL_W-1:CAL_W]);
         write_cal(CSR_TEMP_POINT_HIGH, cal_sets[p][CAL_W-1:0]);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         // Back up the pipeline while the sender keeps offering
         if (p == 0) hold_cycles <= 400;
         for (int i = 0; i < 240; i++) begin
            send_random_reading();
            if (i == 120) begin
               req_chan.valid <= 1'b0;
               @(posedge clock);
               while (pending_count != 0) @(posedge clock);
            end
         end
         wait_idle();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
